FILE: rtl/stwe_pkg.sv
// Shared types, constants and the quarter-wave sine table for the sine tone block.
// No dependencies; every other file in rtl/ imports this package.
package stwe_pkg;

    // Sizing of the sine table and of the output saturation.
    localparam int SINE_TABLE_BITS = 10;
    localparam int SAMPLE_BITS     = 16;
    localparam int SINE_ENTRIES    = 1 << SINE_TABLE_BITS;
    localparam int ROM_ADDR_W      = SINE_TABLE_BITS + 1;

    // Field and state widths.
    localparam int PHASE_W    = 32;
    localparam int AMP_W      = 15;
    localparam int LEN_W      = 16;
    localparam int STEP_W     = 17;
    localparam int ENV_W      = 17;
    localparam int COUNT_W    = 17;
    localparam int SINE_W     = 15;
    localparam int OUT_W      = 16;
    localparam int PROD1_W    = AMP_W + SINE_W;
    localparam int PROD2_W    = PROD1_W + ENV_W;
    localparam int PROD_SHIFT = 31;
    localparam int MAG_W      = PROD2_W - PROD_SHIFT;

    // Envelope full scale in Q1.16.
    localparam logic [ENV_W-1:0] ENV_ONE = ENV_W'(65536);

    // Largest positive output magnitude.
    localparam longint unsigned SAT_LIM = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

    // Configuration port.
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ATTACK_LEN    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_START = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_NOTE_LEN      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ATTACK_STEP   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_STEP  = 3'd6;

    // Current register settings as seen by the datapath.
    typedef struct packed {
        logic [PHASE_W-1:0] phase_step;
        logic [AMP_W-1:0]   amplitude;
        logic [LEN_W-1:0]   attack_len;
        logic [LEN_W-1:0]   release_start;
        logic [LEN_W-1:0]   note_len;
        logic [STEP_W-1:0]  attack_step;
        logic [STEP_W-1:0]  release_step;
    } cfg_t;

    // Commands from the controller to the datapath, one per step of a sample.
    typedef struct packed {
        logic step;
        logic rom_rd;
        logic mul1;
        logic mul2;
        logic load_out;
    } cmd_t;

    // One quarter-wave entry, evaluated with the Q30 Horner series at elaboration.
    function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned k);
        longint unsigned y;
        longint unsigned y2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned v;
        longint unsigned q30_one;
        q30_one = 64'd1 << 30;
        y  = (64'd1686629713 * longint'(k)) >> SINE_TABLE_BITS;
        y2 = (y * y) >> 30;
        t  = q30_one;
        t  = q30_one - ((y2 * t) >> 30) / 110;
        t  = q30_one - ((y2 * t) >> 30) / 72;
        t  = q30_one - ((y2 * t) >> 30) / 42;
        t  = q30_one - ((y2 * t) >> 30) / 20;
        t  = q30_one - ((y2 * t) >> 30) / 6;
        s  = (y * t) >> 30;
        v  = (s * 64'd32767 + (q30_one >> 1)) >> 30;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        return SINE_W'(v);
    endfunction

    typedef logic [SINE_W-1:0] sine_rom_t [SINE_ENTRIES+1];

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t r;
        for (int k = 0; k <= SINE_ENTRIES; k++)
        begin
            r[k] = quarter_sine(k);
        end
        return r;
    endfunction

    // Quarter-wave table, entries 0 to SINE_ENTRIES inclusive.
    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

FILE: rtl/stwe_cfg.sv
// Configuration register file of the sine tone block.
// Depends on stwe_pkg for the register indexes and the cfg_t struct.
module stwe_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [stwe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [stwe_pkg::CFG_DATA_W-1:0]  cfg_data,
    output stwe_pkg::cfg_t                   cfg
);
    import stwe_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode a write into the addressed register; unknown indexes are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PHASE_STEP:    cfg_next.phase_step    = cfg_data[PHASE_W-1:0];
                REG_AMPLITUDE:     cfg_next.amplitude     = cfg_data[AMP_W-1:0];
                REG_ATTACK_LEN:    cfg_next.attack_len    = cfg_data[LEN_W-1:0];
                REG_RELEASE_START: cfg_next.release_start = cfg_data[LEN_W-1:0];
                REG_NOTE_LEN:      cfg_next.note_len      = cfg_data[LEN_W-1:0];
                REG_ATTACK_STEP:   cfg_next.attack_step   = cfg_data[STEP_W-1:0];
                REG_RELEASE_STEP:  cfg_next.release_step  = cfg_data[STEP_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // Registers with their power-on settings (440 Hz tone at 44.1 kHz).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_step    <= PHASE_W'(42852281);
            cfg_reg.amplitude     <= AMP_W'(14000);
            cfg_reg.attack_len    <= LEN_W'(2205);
            cfg_reg.release_start <= LEN_W'(22050);
            cfg_reg.note_len      <= LEN_W'(44100);
            cfg_reg.attack_step   <= STEP_W'(30);
            cfg_reg.release_step  <= STEP_W'(3);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/stwe_ctrl.sv
// Controller of the sine tone block: sequences table read, two multiplies and
// the output load for each sample, and owns both handshakes. Depends on stwe_pkg.
module stwe_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          tick_valid,
    output logic          tick_ready,
    output logic          result_valid,
    input  logic          result_ready,
    output stwe_pkg::cmd_t cmd
);
    import stwe_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ROM  = 3'd1;
    localparam logic [2:0] S_MUL1 = 3'd2;
    localparam logic [2:0] S_MUL2 = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;
    logic       accept;

    // The output register can take a new beat when empty or being drained.
    assign slot_free = !out_valid_reg || result_ready;

    assign tick_ready = (state_reg == S_IDLE) || ((state_reg == S_OUT) && slot_free);
    assign accept     = tick_valid && tick_ready;

    // Next state and datapath commands.
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.step     = accept;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_ROM;
                end
            end
            S_ROM:
            begin
                cmd.rom_rd = 1'b1;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = accept ? S_ROM : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output beat valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

FILE: rtl/stwe_dp.sv
// Datapath of the sine tone block: counter, phase accumulator, envelope,
// sine table read, multiplier chain and output register. Depends on stwe_pkg.
module stwe_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  stwe_pkg::cmd_t             cmd,
    input  stwe_pkg::cfg_t             cfg,
    input  logic                       restart,
    output logic signed [stwe_pkg::OUT_W-1:0] sample,
    output logic                       active
);
    import stwe_pkg::*;

    // Note state.
    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    count_next;
    logic [PHASE_W-1:0]    phase_reg;
    logic [PHASE_W-1:0]    phase_next;
    logic [ENV_W-1:0]      env_reg;
    logic [ENV_W-1:0]      env_next;

    // Per-sample pipeline registers.
    logic [ROM_ADDR_W-1:0] addr_reg;
    logic                  neg_reg;
    logic                  silent_reg;
    logic [ENV_W-1:0]      env_use_reg;
    logic [SINE_W-1:0]     tab_reg;
    logic [PROD1_W-1:0]    prod1_reg;
    logic [PROD2_W-1:0]    prod2_reg;
    logic signed [OUT_W-1:0] sample_reg;
    logic                  active_reg;

    // Values at the start of a sample, after an optional restart.
    logic [COUNT_W-1:0]    cnt_cur;
    logic [PHASE_W-1:0]    ph_cur;
    logic [ENV_W-1:0]      env_cur;
    logic                  silent;
    logic [ENV_W:0]        env_sum;
    logic [ENV_W-1:0]      env_upd;
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [ROM_ADDR_W-1:0] addr;
    logic [MAG_W-1:0]      mag;
    logic [MAG_W-1:0]      mag_sat;
    logic [OUT_W-1:0]      out_bits;

    assign cnt_cur = restart ? '0 : count_reg;
    assign ph_cur  = restart ? '0 : phase_reg;
    assign env_cur = restart ? '0 : env_reg;
    assign silent  = cnt_cur > {1'b0, cfg.note_len};

    // Envelope update: attack wins over release; no change on the first sample.
    assign env_sum = {1'b0, env_cur} + {1'b0, cfg.attack_step};
    always_comb
    begin
        if (cnt_cur <= {1'b0, cfg.attack_len})
        begin
            if (cnt_cur != '0)
            begin
                env_upd = (env_sum > {1'b0, ENV_ONE}) ? ENV_ONE : env_sum[ENV_W-1:0];
            end
            else
            begin
                env_upd = env_cur;
            end
        end
        else if (cnt_cur >= {1'b0, cfg.release_start})
        begin
            env_upd = (env_cur >= cfg.release_step) ? env_cur - cfg.release_step : '0;
        end
        else
        begin
            env_upd = ENV_ONE;
        end
    end

    // Table address; odd quadrants run the quarter wave backwards.
    assign idx  = ph_cur[PHASE_W-3 -: SINE_TABLE_BITS];
    assign addr = ph_cur[PHASE_W-2] ? ROM_ADDR_W'(SINE_ENTRIES) - {1'b0, idx}
                                    : {1'b0, idx};

    // State advance; a silent note keeps its state.
    always_comb
    begin
        count_next = count_reg;
        phase_next = phase_reg;
        env_next   = env_reg;
        if (cmd.step && !silent)
        begin
            count_next = cnt_cur + COUNT_W'(1);
            phase_next = ph_cur + cfg.phase_step;
            env_next   = env_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            phase_reg <= '0;
            env_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            phase_reg <= phase_next;
            env_reg   <= env_next;
        end
    end

    // Saturate the scaled magnitude and apply the sign of the half wave.
    assign mag      = prod2_reg[PROD2_W-1 -: MAG_W];
    assign mag_sat  = (64'(mag) > SAT_LIM) ? MAG_W'(SAT_LIM) : mag;
    assign out_bits = neg_reg ? OUT_W'(-mag_sat) : OUT_W'(mag_sat);

    // Pipeline: capture, table read, two multiplies, output load.
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            addr_reg    <= addr;
            neg_reg     <= ph_cur[PHASE_W-1];
            silent_reg  <= silent;
            env_use_reg <= env_upd;
        end
        if (cmd.rom_rd)
        begin
            tab_reg <= SINE_ROM[addr_reg];
        end
        if (cmd.mul1)
        begin
            prod1_reg <= PROD1_W'(cfg.amplitude) * PROD1_W'(tab_reg);
        end
        if (cmd.mul2)
        begin
            prod2_reg <= PROD2_W'(prod1_reg) * PROD2_W'(env_use_reg);
        end
        if (cmd.load_out)
        begin
            sample_reg <= silent_reg ? '0 : $signed(out_bits);
            active_reg <= !silent_reg;
        end
    end

    assign sample = sample_reg;
    assign active = active_reg;

endmodule

FILE: rtl/sine_tone_with_envelope.sv
// Top level of the sine tone with attack/sustain/release envelope.
// Depends on stwe_pkg, stwe_cfg, stwe_ctrl and stwe_dp.
//
// Each tick beat yields one result beat: a signed 16-bit sample of a sine note
// from a 32-bit phase accumulator and a 1025-entry quarter-wave table, scaled
// by amplitude and a linear Q1.16 envelope, plus an active flag that is low
// once the sample count has passed note_len. A restart flag on the tick starts
// the note over. An accepted tick goes through state update and table address,
// a registered table read, the amplitude multiply and the envelope multiply
// into the output register; the sequencer handles one sample at a time and
// takes the next tick in the cycle the output register is loaded, so a new
// tick is not taken before the last sample is through. Register writes go
// through cfg_we/cfg_index/cfg_data; the user must make them only while idle,
// which the block does not enforce. They apply from the next sample.
module sine_tone_with_envelope (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [stwe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [stwe_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             tick_valid,
    output logic                             tick_ready,
    input  logic                             restart,
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic signed [stwe_pkg::OUT_W-1:0] sample,
    output logic                             active
);
    import stwe_pkg::*;

    cfg_t cfg;
    cmd_t cmd;

    // Register file.
    stwe_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sequencer and handshakes.
    stwe_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_ready   (tick_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd)
    );

    // Arithmetic and note state.
    stwe_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .cfg     (cfg),
        .restart (restart),
        .sample  (sample),
        .active  (active)
    );

endmodule

FILE: bench/testbench.sv
// Self-checking bench for sine_tone_with_envelope: directed ticks, then random notes and register settings.
// Each result beat is checked against a built-in model of the oscillator and its envelope.
// Depends on rtl/stwe_pkg.sv and rtl/sine_tone_with_envelope.sv.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int              TABLE_BITS   = 10;
    localparam int              TABLE_SIZE   = 1 << TABLE_BITS;
    localparam int unsigned     ENV_FULL     = 65536;
    localparam longint unsigned PEAK         = 32767;
    localparam int              REPORT_LIMIT = 10;
    localparam int              RANDOM_TICKS = 1000;

    typedef logic [stwe_pkg::CFG_INDEX_W-1:0] reg_index_t;
    typedef logic [stwe_pkg::CFG_DATA_W-1:0]  reg_data_t;

    typedef enum logic {STEP_TICK, STEP_WRITE} plan_kind_e;

    // One row of the directed plan: a register write or a tick, optionally
    // with its result pinned by hand.
    typedef struct packed {
        plan_kind_e         kind;
        reg_index_t         index;
        reg_data_t          data;
        logic               restart;
        logic               pinned;
        logic signed [15:0] pin_sample;
        logic               pin_active;
    } plan_row_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               active;
    } tone_beat_t;

    logic                clk;
    logic                rst_n        = 1'b0;
    logic                cfg_we       = 1'b0;
    reg_index_t          cfg_index    = stwe_pkg::REG_PHASE_STEP;
    reg_data_t           cfg_data     = '0;
    logic                tick_valid   = 1'b0;
    logic                tick_ready;
    logic                restart      = 1'b0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    logic signed [15:0]  sample;
    logic                active;

    // Model copy of the register file, at reset values.
    logic [31:0] set_phase_step    = 32'd42852281;
    logic [14:0] set_amplitude     = 15'd14000;
    logic [15:0] set_attack_len    = 16'd2205;
    logic [15:0] set_release_start = 16'd22050;
    logic [15:0] set_note_len      = 16'd44100;
    logic [16:0] set_attack_step   = 17'd30;
    logic [16:0] set_release_step  = 17'd3;

    // Model copy of the oscillator state.
    logic [16:0] note_count = '0;
    logic [31:0] phase_acc  = '0;
    logic [16:0] env_level  = '0;

    int unsigned sine_quarter [0:TABLE_SIZE];
    tone_beat_t  pending_samples [$];
    int          error_count   = 0;
    bit          tick_gaps_off = 1'b0;

    sine_tone_with_envelope u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .tick_valid   (tick_valid),
        .tick_ready   (tick_ready),
        .restart      (restart),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .sample       (sample),
        .active       (active)
    );

    // Directed plan: reset state, peak and zero crossings, note end, restart
    // while silent, zero amplitude, attack overlapping release, a note length
    // cut below the current count, and oversized release step.
    plan_row_t directed_plan [] = '{
        '{STEP_TICK,  stwe_pkg::REG_PHASE_STEP,    32'd0,          1'b0, 1'b1, 16'sd0, 1'b1},
        '{STEP_TICK,  stwe_pkg::REG_PHASE_STEP,    32'd0,          1'b0, 1'b0, 16'sd0, 1'b0},
        '{STEP_WRITE, stwe_pkg::REG_ATTACK_STEP,   32'd65536,      1'b0, 1'b0, 16'sd0, 1'b0},
        '{STEP_WRITE, stwe_pkg::REG_PHASE_STEP,    32'h4000_0000,  1'b0, 1'b0, 16'sd0, 1'b0},
        '{STEP_WRITE, stwe_pkg::REG_AMPLITUDE,     32'd32767,      1'b0, 1'b0, 16'sd0, 1'b0},
        '{STEP_TICK,  stwe_pkg::REG_PHASE_STEP,    32'd0,          1'b1, 1'b1, 16'sd0, 1'b1},
        '{STEP_TICK,  stwe_pkg::REG_PHASE_STEP,    32'd0,          1'b0, 1'b0, 16'sd0, 1'b0},
        '{STEP_TICK,  stwe_pkg::REG_PHASE_STEP,    32'd0,          1'b0, 1'b1, 16'sd0, 1'b1},
        '{STEP_TICK,  stwe_pkg::REG_PHASE_STEP,    32'd0,          1'b0, 1'b0, 16'sd0, 1'b0},
        '{STEP_WRITE, stwe_pkg::REG_NOTE_LEN,      32'd4,          1'b0, 1'b0, 16'sd0, 1'b0},
        '{STEP_TICK,  stwe_pkg::REG_PHASE_STEP,    32'd0,          1'b0, 1'b0, 16'sd0, 1'b0},
        '{STEP_TICK,  stwe_pkg::REG_PHASE_STEP,    32'd0,          1'b0, 1'b1, 16'sd0, 1'b0},
        '{STEP_TICK,  stwe_pkg::REG_PHASE_STEP,    32'd0,          1'b0, 1'b1, 16'sd0, 1'b0},
        '{STEP_TICK,  stwe_pkg::REG_PHASE_STEP,    32'd0,          1'b1, 1'b1, 16'sd0, 1'b1},
        '{STEP_WRITE, stwe_pkg::REG_AMPLITUDE,     32'd0,          1'b0, 1'b0, 16'sd0, 1'b0},
        '{STEP_TICK,  stwe_pkg::REG_PHASE_STEP,    32'd0,          1'b0, 1'b1, 16'sd0, 1'b1},
        '{STEP_TICK,  stwe_pkg::REG_PHASE_STEP,    32'd0,          1'b0, 1'b1, 16'sd0, 1'b1},
        '{STEP_WRITE, stwe_pkg::REG_AMPLITUDE,     32'd32767,      1'b0, 1'b0, 16'sd0, 1'b0},
        '{STEP_WRITE, stwe_pkg::REG_PHASE_STEP,    32'hFFFF_FFFF,  1'b0, 1'b0, 16'sd0, 1'b0},
        '{STEP_WRITE, stwe_pkg::REG_ATTACK_LEN,    32'd10,         1'b0, 1'b0, 16'sd0, 1'b0},
        '{STEP_WRITE, stwe_pkg::REG_RELEASE_START, 32'd2,          1'b0, 1'b0, 16'sd0, 1'b0},
        '{STEP_WRITE, stwe_pkg::REG_NOTE_LEN,      32'd30,         1'b0, 1'b0, 16'sd0, 1'b0},
        '{STEP_WRITE, stwe_pkg::REG_ATTACK_STEP,   32'd20000,      1'b0, 1'b0, 16'sd0, 1'b0},
        '{STEP_WRITE, stwe_pkg::REG_RELEASE_STEP,  32'd65536,      1'b0, 1'b0, 16'sd0, 1'b0},
        '{STEP_TICK,  stwe_pkg::REG_PHASE_STEP,    32'd0,          1'b1, 1'b1, 16'sd0, 1'b1},
        '{STEP_TICK,  stwe_pkg::REG_PHASE_STEP,    32'd0,          1'b0, 1'b0, 16'sd0, 1'b0},
        '{STEP_TICK,  stwe_pkg::REG_PHASE_STEP,    32'd0,          1'b0, 1'b0, 16'sd0, 1'b0},
        '{STEP_TICK,  stwe_pkg::REG_PHASE_STEP,    32'd0,          1'b0, 1'b0, 16'sd0, 1'b0},
        '{STEP_TICK,  stwe_pkg::REG_PHASE_STEP,    32'd0,          1'b0, 1'b0, 16'sd0, 1'b0},
        '{STEP_TICK,  stwe_pkg::REG_PHASE_STEP,    32'd0,          1'b0, 1'b0, 16'sd0, 1'b0},
        '{STEP_TICK,  stwe_pkg::REG_PHASE_STEP,    32'd0,          1'b0, 1'b0, 16'sd0, 1'b0},
        '{STEP_WRITE, stwe_pkg::REG_NOTE_LEN,      32'd1,          1'b0, 1'b0, 16'sd0, 1'b0},
        '{STEP_TICK,  stwe_pkg::REG_PHASE_STEP,    32'd0,          1'b0, 1'b1, 16'sd0, 1'b0},
        '{STEP_WRITE, stwe_pkg::REG_ATTACK_LEN,    32'd0,          1'b0, 1'b0, 16'sd0, 1'b0},
        '{STEP_WRITE, stwe_pkg::REG_RELEASE_START, 32'd3,          1'b0, 1'b0, 16'sd0, 1'b0},
        '{STEP_WRITE, stwe_pkg::REG_NOTE_LEN,      32'd65535,      1'b0, 1'b0, 16'sd0, 1'b0},
        '{STEP_WRITE, stwe_pkg::REG_RELEASE_STEP,  32'd131071,     1'b0, 1'b0, 16'sd0, 1'b0},
        '{STEP_WRITE, stwe_pkg::REG_PHASE_STEP,    32'h0100_0000,  1'b0, 1'b0, 16'sd0, 1'b0},
        '{STEP_TICK,  stwe_pkg::REG_PHASE_STEP,    32'd0,          1'b1, 1'b1, 16'sd0, 1'b1},
        '{STEP_TICK,  stwe_pkg::REG_PHASE_STEP,    32'd0,          1'b0, 1'b0, 16'sd0, 1'b0},
        '{STEP_TICK,  stwe_pkg::REG_PHASE_STEP,    32'd0,          1'b0, 1'b0, 16'sd0, 1'b0},
        '{STEP_TICK,  stwe_pkg::REG_PHASE_STEP,    32'd0,          1'b0, 1'b1, 16'sd0, 1'b1}
    };

    // Quarter-wave entry k: fixed-point Q30 Taylor series of sin, evaluated
    // innermost term first, then scaled to 15 bits with rounding.
    function automatic int unsigned horner_sine(int unsigned k);
        longint unsigned q_one;
        longint unsigned y;
        longint unsigned y2;
        longint unsigned t;
        longint unsigned v;
        int unsigned     divisors [5];
        q_one    = 64'd1 << 30;
        divisors = '{110, 72, 42, 20, 6};
        y        = (64'd1686629713 * longint'(k)) >> TABLE_BITS;
        y2       = (y * y) >> 30;
        t        = q_one;
        foreach (divisors[i])
        begin
            t = q_one - ((y2 * t) >> 30) / divisors[i];
        end
        v = (((y * t) >> 30) * 64'd32767 + (q_one >> 1)) >> 30;
        return (v > PEAK) ? int'(PEAK) : int'(v);
    endfunction

    // Track a register write in the model, cut to the register's width.
    function automatic void apply_setting(reg_index_t index, reg_data_t data);
        case (index)
            stwe_pkg::REG_PHASE_STEP:    set_phase_step    = data;
            stwe_pkg::REG_AMPLITUDE:     set_amplitude     = data[14:0];
            stwe_pkg::REG_ATTACK_LEN:    set_attack_len    = data[15:0];
            stwe_pkg::REG_RELEASE_START: set_release_start = data[15:0];
            stwe_pkg::REG_NOTE_LEN:      set_note_len      = data[15:0];
            stwe_pkg::REG_ATTACK_STEP:   set_attack_step   = data[16:0];
            stwe_pkg::REG_RELEASE_STEP:  set_release_step  = data[16:0];
            default: ;
        endcase
    endfunction

    // Advance the model by one tick and return the sample it must produce.
    function automatic tone_beat_t predict_tone(logic restart_note);
        tone_beat_t      beat;
        int unsigned     raised;
        logic [1:0]      quad;
        int unsigned     idx;
        longint unsigned mag;
        if (restart_note)
        begin
            note_count = '0;
            phase_acc  = '0;
            env_level  = '0;
        end

        // Silent past the note end; nothing moves until a restart or a larger note_len.
        if (note_count > set_note_len)
        begin
            beat.sample = '0;
            beat.active = 1'b0;
            return beat;
        end

        // Envelope: attack takes priority over release; the first sample of
        // the attack keeps the level unchanged.
        if (note_count <= set_attack_len)
        begin
            if (note_count != 0)
            begin
                raised    = env_level + set_attack_step;
                env_level = (raised > ENV_FULL) ? 17'(ENV_FULL) : 17'(raised);
            end
        end
        else if (note_count >= set_release_start)
        begin
            env_level = (env_level >= set_release_step) ? env_level - set_release_step : '0;
        end
        else
        begin
            env_level = 17'(ENV_FULL);
        end

        // Odd quadrants read the table backward, the lower half is negated.
        quad = phase_acc[31:30];
        idx  = phase_acc[29 -: TABLE_BITS];
        mag  = set_amplitude;
        mag  = mag * (quad[0] ? sine_quarter[TABLE_SIZE - idx] : sine_quarter[idx]);
        mag  = (mag * env_level) >> 31;
        if (mag > PEAK)
        begin
            mag = PEAK;
        end
        beat.sample = quad[1] ? (16'd0 - mag[15:0]) : mag[15:0];
        beat.active = 1'b1;

        phase_acc  = phase_acc + set_phase_step;
        note_count = note_count + 17'd1;
        return beat;
    endfunction

    function automatic void flag_error(string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
        begin
            $display("%0t: %s", $time, msg);
        end
    endfunction

    // Idle stretch length: mostly none or short, now and then long.
    function automatic int idle_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Random register value; lengths are kept short most of the time so that
    // notes run through attack, release and silence within a batch.
    function automatic reg_data_t random_value(reg_index_t index);
        int unsigned pick;
        pick = $urandom_range(0, 9);
        case (index)
            stwe_pkg::REG_PHASE_STEP:
                case (pick)
                    0: return '0;
                    1: return 32'hFFFF_FFFF;
                    2: return $urandom_range(1, 1 << 22);
                    default: return $urandom;
                endcase
            stwe_pkg::REG_AMPLITUDE:
                case (pick)
                    0: return '0;
                    1: return 32'd32767;
                    2: return $urandom;
                    default: return $urandom_range(0, 32767);
                endcase
            stwe_pkg::REG_ATTACK_STEP, stwe_pkg::REG_RELEASE_STEP:
                case (pick)
                    0: return '0;
                    1: return 32'd65536;
                    2: return 32'd131071;
                    3: return $urandom;
                    default: return $urandom_range(1, 12000);
                endcase
            default:
                case (pick)
                    0: return '0;
                    1: return 32'd65535;
                    2: return $urandom;
                    default: return $urandom_range(0, (index == stwe_pkg::REG_NOTE_LEN) ? 120 : 60);
                endcase
        endcase
    endfunction

    // Send one tick beat, record what it must produce once it is taken.
    task automatic drive_tick(logic restart_note, logic pinned, logic signed [15:0] pin_sample,
                              logic pin_active);
        int         gap;
        tone_beat_t beat;
        gap = tick_gaps_off ? 0 : idle_length();
        if (gap > 0)
        begin
            tick_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_valid <= 1'b1;
        restart    <= restart_note;
        @(posedge clk);
        while (!tick_ready)
        begin
            @(posedge clk);
        end
        beat = predict_tone(restart_note);
        if (pinned)
        begin
            beat.sample = pin_sample;
            beat.active = pin_active;
        end
        pending_samples.push_back(beat);
    endtask

    // Stop sending and wait until every outstanding sample has come back.
    task automatic drain();
        tick_valid <= 1'b0;
        while (pending_samples.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t index, reg_data_t data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        apply_setting(index, data);
        @(posedge clk);
    endtask

    task automatic randomize_settings(bit write_all);
        reg_index_t all_regs [7];
        all_regs = '{stwe_pkg::REG_PHASE_STEP, stwe_pkg::REG_AMPLITUDE, stwe_pkg::REG_ATTACK_LEN,
                     stwe_pkg::REG_RELEASE_START, stwe_pkg::REG_NOTE_LEN,
                     stwe_pkg::REG_ATTACK_STEP, stwe_pkg::REG_RELEASE_STEP};
        foreach (all_regs[i])
        begin
            if (write_all || $urandom_range(0, 2) != 0)
            begin
                write_reg(all_regs[i], random_value(all_regs[i]));
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("sine_tone_with_envelope test failed");
        $finish;
    end

    // Result side back-pressure: short and long stalls between open stretches.
    initial
    begin
        int   hold;
        logic level;
        hold  = 0;
        level = 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold <= 0)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    level = 1'b0;
                    hold  = 1 + idle_length();
                end
                else
                begin
                    level = 1'b1;
                    hold  = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
                                                        : $urandom_range(1, 40);
                end
            end
            result_ready <= level;
            hold--;
        end
    end

    // Compare every result beat with the oldest outstanding sample.
    always @(posedge clk)
    begin
        tone_beat_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_samples.size() == 0)
            begin
                flag_error($sformatf("result beat with nothing outstanding: sample %0d active %0b",
                                     sample, active));
            end
            else
            begin
                want = pending_samples.pop_front();
                if (sample !== want.sample)
                    flag_error($sformatf("sample mismatch: expected %0d, got %0d",
                                         want.sample, sample));
                if (active !== want.active)
                    flag_error($sformatf("active mismatch: expected %0b, got %0b",
                                         want.active, active));
            end
        end
    end

    // Main sequence: reset, directed plan, random notes, final drain.
    initial
    begin
        int tone_ticks_sent;
        int batch;
        bit first_round;
        for (int k = 0; k <= TABLE_SIZE; k++)
        begin
            sine_quarter[k] = horner_sine(k);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].kind == STEP_WRITE)
            begin
                drain();
                write_reg(directed_plan[i].index, directed_plan[i].data);
            end
            else
            begin
                drive_tick(directed_plan[i].restart, directed_plan[i].pinned,
                           directed_plan[i].pin_sample, directed_plan[i].pin_active);
            end
        end

        // Random batches, each under a fresh setting and mostly starting a new note.
        tone_ticks_sent = 0;
        first_round     = 1'b1;
        while (tone_ticks_sent < RANDOM_TICKS)
        begin
            drain();
            randomize_settings(first_round);
            first_round   = 1'b0;
            tick_gaps_off = ($urandom_range(0, 3) == 0);
            batch         = $urandom_range(20, 100);
            for (int j = 0; j < batch; j++)
            begin
                drive_tick((j == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 29) == 0),
                           1'b0, 16'sd0, 1'b0);
                tone_ticks_sent++;
            end
        end

        drain();
        repeat (16) @(posedge clk);
        if (error_count == 0)
            $display("sine_tone_with_envelope test passed");
        else
            $display("sine_tone_with_envelope test failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/stwe_pkg.sv
rtl/stwe_cfg.sv
rtl/stwe_ctrl.sv
rtl/stwe_dp.sv
rtl/sine_tone_with_envelope.sv
bench/testbench.sv
